// File: rtl/lir_pkg.sv
// lir_pkg: widths, constants and shared types of the linear resampler.
// No dependencies; used by every module of the block.
package lir_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 22;
	localparam int OFF_W     = STEP_W + 1;
	localparam int DIFF_W    = SAMPLE_W + 1;
	localparam int DIGIT_W   = 4;
	localparam int N_DIGITS  = FRAC_BITS / DIGIT_W;
	localparam int DCNT_W    = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;
	localparam int ACC_W     = DIFF_W + DIGIT_W + 1;
	localparam int HALF_CAP  = 32;
	localparam int K_W       = $clog2(HALF_CAP + 1);

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_PHASE_STEP = 0;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(65536);

	localparam logic [OFF_W-1:0] ONE_Q = OFF_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic                       start;
		logic signed [SAMPLE_W-1:0] a;
		logic signed [DIFF_W-1:0]   d;
		logic [FRAC_BITS-1:0]       c;
	} mul_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] y;
	} mul_rsp_t;

endpackage

// File: rtl/lir_cfg.sv
// lir_cfg: APB-style register file holding the phase step.
// Depends on lir_pkg.
module lir_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lir_pkg::PADDR_W-1:0]     paddr,
	input  logic [lir_pkg::PDATA_W-1:0]     pwdata,
	output logic [lir_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	output logic [lir_pkg::STEP_W-1:0]      phase_step
);

	logic [lir_pkg::STEP_W-1:0] step_q;
	logic                       sel_step;

	assign sel_step = (paddr == lir_pkg::PADDR_W'(lir_pkg::REG_PHASE_STEP * 4));
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lir_pkg::PHASE_STEP_RST;
		end else if (psel && penable && pwrite && sel_step) begin
			step_q <= pwdata[lir_pkg::STEP_W-1:0];
		end
	end

	assign prdata = sel_step ? lir_pkg::PDATA_W'(step_q) : '0;
	assign phase_step = step_q;

endmodule

// File: rtl/lir_dsmul.sv
// lir_dsmul: digit-serial interpolator, a + c*d over 2^FRAC_BITS truncated to zero.
// Consumes the fraction c one digit per cycle, LSB first. Depends on lir_pkg.
module lir_dsmul (
	input  logic              clk,
	input  logic              arst_n,
	input  lir_pkg::mul_req_t req,
	output lir_pkg::mul_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [lir_pkg::DCNT_W-1:0]          cnt_q;
	logic [lir_pkg::FRAC_BITS-1:0]       c_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] a_q;
	logic signed [lir_pkg::DIFF_W-1:0]   d_q;
	logic signed [lir_pkg::ACC_W-1:0]    acc_q;
	logic                                nz_q;

	logic signed [lir_pkg::ACC_W-1:0]    pp;
	logic signed [lir_pkg::ACC_W-1:0]    sum;
	logic signed [lir_pkg::ACC_W-1:0]    s;
	logic signed [lir_pkg::ACC_W-1:0]    s_fix;

	assign pp  = lir_pkg::ACC_W'(d_q) *
		lir_pkg::ACC_W'($signed({1'b0, c_q[lir_pkg::DIGIT_W-1:0]}));
	assign sum = acc_q + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lir_pkg::DCNT_W'(lir_pkg::N_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			d_q   <= req.d;
			c_q   <= req.c;
			acc_q <= '0;
			nz_q  <= 1'b0;
		end else if (busy_q) begin
			acc_q <= sum >>> lir_pkg::DIGIT_W;
			nz_q  <= nz_q | (|sum[lir_pkg::DIGIT_W-1:0]);
			c_q   <= c_q >> lir_pkg::DIGIT_W;
		end
	end

	// floor result plus one when negative with a nonzero fraction
	assign s     = lir_pkg::ACC_W'(a_q) + acc_q;
	assign s_fix = s + lir_pkg::ACC_W'($signed({1'b0, s[lir_pkg::ACC_W-1] & nz_q}));

	assign rsp.done = done_q;
	assign rsp.y    = s_fix[lir_pkg::SAMPLE_W-1:0];

endmodule

// File: rtl/linear_interp_resampler.sv
// linear_interp_resampler: top level, segment sequencer and output register.
// Depends on lir_pkg, lir_cfg and lir_dsmul.
//
// Input words (in_sample, is_last) are taken on in_valid with in_stall low;
// result words (out_sample, run_end) leave on out_valid with out_stall low.
// The phase step sits at APB byte address 0, reset value 1.0 in Q6.16.
// One input word is worked at a time. Each position inside the segment passes
// a check, the digit steps and result of the serial multiplier (16-bit
// fraction, 4 bits a cycle) and a write-back; a tail position after the last
// word passes a check and a write-back. An input word keeps in_stall high
// until its results, and the tail results when it is marked last, have left
// the sequencer.
// Each result is held one step so run_end can be set on the final one; it
// reaches the output register when the next result is ready or the word ends.
// The final result may still wait in the output register while the next input
// word is taken. A stall on the output freezes the sequencer once a held result
// must move to the output register, and holds the output word unchanged.
// Reset clears the stream state and the output valid flag and sets the step to 1.0.
module linear_interp_resampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                is_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                run_end,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lir_pkg::PADDR_W-1:0]         paddr,
	input  logic [lir_pkg::PDATA_W-1:0]         pwdata,
	output logic [lir_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SEG  = 6'b000010,
		S_MUL  = 6'b000100,
		S_PUT  = 6'b001000,
		S_TAIL = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                              state_q;
	logic [lir_pkg::STEP_W-1:0]          phase_step;
	logic signed [lir_pkg::SAMPLE_W-1:0] prev_q;
	logic                                have_q;
	logic [lir_pkg::OFF_W-1:0]           off_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] cur_q;
	logic                                last_q;
	logic                                tail_q;
	logic [lir_pkg::K_W-1:0]             k_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] res_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] pend_q;
	logic                                pend_v_q;
	logic                                out_valid_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                run_end_q;

	lir_pkg::mul_req_t                   mreq;
	lir_pkg::mul_rsp_t                   mrsp;
	logic                                in_seg;
	logic                                room;
	logic                                out_free;

	lir_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.phase_step (phase_step)
	);

	lir_dsmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign in_seg   = off_q < lir_pkg::ONE_Q;
	assign room     = k_q < lir_pkg::K_W'(lir_pkg::HALF_CAP);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mreq.start = (state_q == S_SEG) && have_q && in_seg && room;
		mreq.a     = prev_q;
		mreq.d     = lir_pkg::DIFF_W'(cur_q) - lir_pkg::DIFF_W'(prev_q);
		mreq.c     = off_q[lir_pkg::FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			have_q      <= 1'b0;
			off_q       <= '0;
			tail_q      <= 1'b0;
			k_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q     <= '0;
						tail_q  <= 1'b0;
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					if (have_q && in_seg && room) begin
						state_q <= S_MUL;
					end else begin
						// clamp a capped segment to its end, then rebase
						off_q  <= in_seg ? '0 : off_q - lir_pkg::ONE_Q;
						prev_q <= cur_q;
						have_q <= 1'b1;
						if (last_q) begin
							tail_q  <= 1'b1;
							k_q     <= '0;
							state_q <= S_TAIL;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MUL: begin
					if (mrsp.done)
						state_q <= S_PUT;
				end
				S_PUT: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						off_q    <= off_q + lir_pkg::OFF_W'(phase_step);
						k_q      <= k_q + 1'b1;
						state_q  <= tail_q ? S_TAIL : S_SEG;
					end
				end
				S_TAIL: begin
					if (in_seg && room) begin
						state_q <= S_PUT;
					end else begin
						prev_q  <= '0;
						have_q  <= 1'b0;
						off_q   <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cur_q  <= in_sample;
			last_q <= is_last;
		end
		if (state_q == S_MUL && mrsp.done)
			res_q <= mrsp.y;
		if (state_q == S_TAIL)
			res_q <= cur_q;
		if (state_q == S_PUT && (!pend_v_q || out_free)) begin
			pend_q <= res_q;
			if (pend_v_q) begin
				out_sample_q <= pend_q;
				run_end_q    <= 1'b0;
			end
		end
		if (state_q == S_FIN && pend_v_q && out_free) begin
			out_sample_q <= pend_q;
			run_end_q    <= 1'b1;
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign run_end    = run_end_q;

endmodule

// File: rtl/lir_chk.sv
// lir_chk: port-level checks of the linear resampler, bound to the top level.
// Depends on lir_pkg and the linear_interp_resampler ports only.
module lir_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
	input logic                                run_end,
	input logic                                pready
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(run_end))
		else $error("output word changed under stall");

	// one word at a time: the input closes right after an accept
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accept");

	// results are only produced while a word is being worked
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output appeared while sequencer idle");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind linear_interp_resampler lir_chk u_lir_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_sample (out_sample),
	.run_end    (run_end),
	.pready     (pready)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for linear_interp_resampler. Streams audio words through
// the block, predicts every resampled word in Q16.16 and checks them in order.
// Depends on lir_pkg and the block's RTL only.
module tb;

	localparam int SW   = lir_pkg::SAMPLE_W;
	localparam int SPW  = lir_pkg::STEP_W;
	localparam int AW   = lir_pkg::PADDR_W;
	localparam int DW   = lir_pkg::PDATA_W;
	localparam int FRAC = lir_pkg::FRAC_BITS;

	localparam logic [AW-1:0] ADDR_STEP  = AW'(4 * lir_pkg::REG_PHASE_STEP);
	localparam logic [AW-1:0] ADDR_SPARE = AW'(4 * (lir_pkg::REG_PHASE_STEP + 1));

	localparam logic [31:0] UNIT    = 32'(1) << FRAC;
	localparam int          RUN_CAP = 32;
	localparam int          SETTLE  = 40;

	localparam logic [DW-1:0] STEP_LO  = DW'(2048);
	localparam logic [DW-1:0] STEP_HI  = DW'(2097152);
	localparam logic [DW-1:0] STEP_MAX = DW'({SPW{1'b1}});
	localparam logic [DW-1:0] STEP_NIL = '0;

	localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef struct packed {
		logic signed [SW-1:0] smp;
		logic                 fin;
	} res_word_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] in_sample = '0;
	logic                 is_last   = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] out_sample;
	logic                 run_end;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [AW-1:0]        paddr     = '0;
	logic [DW-1:0]        pwdata    = '0;
	logic [DW-1:0]        prdata;
	logic                 pready;

	// stream state of the predictor
	logic signed [SW-1:0] prev_smp  = '0;
	bit                   prev_ok   = 1'b0;
	logic [31:0]          pos       = '0;
	logic [SPW-1:0]       rate_step = lir_pkg::PHASE_STEP_RST;

	res_word_t due_words[$];
	bit        calm   = 1'b0;
	int        errors = 0;
	int        n_in   = 0;
	int        n_out  = 0;
	int        n_cfg  = 0;

	linear_interp_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_sample (in_sample),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_sample(out_sample),
		.run_end   (run_end),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	// (1 - c) * a + c * b in Q16.16, truncated toward zero
	function automatic logic signed [SW-1:0] weigh_pair(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b, input logic [31:0] at);
		longint frac;
		longint acc;
		longint mag;
		frac = longint'(at[FRAC-1:0]);
		acc = longint'(a) * longint'(UNIT) + frac * (longint'(b) - longint'(a));
		if (acc < 0) begin
			mag = -((-acc) >>> FRAC);
		end else begin
			mag = acc >>> FRAC;
		end
		return SW'(mag);
	endfunction

	function automatic void advance_stream(input logic signed [SW-1:0] s, input logic l);
		int        k;
		int        first;
		res_word_t w;
		first = due_words.size();
		if (prev_ok) begin
			k = 0;
			while (pos < UNIT && k < RUN_CAP) begin
				w.smp = weigh_pair(prev_smp, s, pos);
				w.fin = 1'b0;
				due_words.push_back(w);
				pos += 32'(rate_step);
				k++;
			end
			if (pos < UNIT)
				pos = UNIT;
			pos -= UNIT;
		end
		prev_smp = s;
		prev_ok = 1'b1;
		if (l) begin
			k = 0;
			while (pos < UNIT && k < RUN_CAP) begin
				w.smp = s;
				w.fin = 1'b0;
				due_words.push_back(w);
				pos += 32'(rate_step);
				k++;
			end
			prev_smp = '0;
			prev_ok = 1'b0;
			pos = '0;
		end
		if (due_words.size() > first) begin
			w = due_words.pop_back();
			w.fin = 1'b1;
			due_words.push_back(w);
		end
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			1: return SW'($urandom_range(0, 64)) - SW'(32);
			default: return SW'($urandom());
		endcase
	endfunction

	task automatic send_word(input logic signed [SW-1:0] s, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= s;
		is_last   <= l;
		do @(posedge clk); while (in_stall);
		advance_stream(s, l);
		n_in++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write while idle, then read the step register back
	task automatic set_reg(input logic [AW-1:0] addr, input logic [DW-1:0] data);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_STEP)
			rate_step = data[SPW-1:0];
		n_cfg++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_STEP;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DW'(rate_step)) begin
			errors++;
			$error("prdata: expected %0h, got %0h", DW'(rate_step), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : result_check
		int        hold;
		res_word_t w;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				n_out++;
				if (due_words.size() == 0) begin
					errors++;
					$error("unexpected word: out_sample %0d, run_end %0b", out_sample, run_end);
				end else begin
					w = due_words.pop_front();
					if (out_sample !== w.smp) begin
						errors++;
						$error("out_sample: expected %0d, got %0d", w.smp, out_sample);
					end
					if (run_end !== w.fin) begin
						errors++;
						$error("run_end: expected %0b, got %0b", w.fin, run_end);
					end
				end
				hold = calm ? 0 : $urandom_range(0, 16);
			end else if (hold > 0) begin
				hold--;
			end
			out_stall <= (hold > 0);
		end
	end

	// step of one: plain copy, field extremes
	task automatic test_copy();
		send_word(SW'(16'h1234), 1'b0);
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MIN, 1'b0);
		send_word(-SW'(1), 1'b0);
		send_word('0, 1'b0);
		send_word(SW'(1), 1'b1);
	endtask

	task automatic test_lone_sample();
		send_word(-SW'(1234), 1'b1);
	endtask

	task automatic test_upsample();
		set_reg(ADDR_STEP, STEP_LO);
		send_word(SMP_MAX, 1'b1);
		send_word(SMP_MIN, 1'b0);
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MIN, 1'b1);
	endtask

	// most segments hold no position
	task automatic test_downsample();
		set_reg(ADDR_STEP, STEP_HI);
		for (int i = 0; i < 6; i++)
			send_word(pick_sample(), i == 5);
	endtask

	// capped runs, segment and tail
	task automatic test_zero_step();
		set_reg(ADDR_STEP, STEP_NIL);
		send_word(SW'(100), 1'b0);
		send_word(-SW'(100), 1'b1);
	endtask

	task automatic test_top_step();
		set_reg(ADDR_STEP, STEP_MAX);
		for (int i = 0; i < 3; i++)
			send_word(pick_sample(), i == 2);
	endtask

	task automatic test_spare_reg();
		set_reg(ADDR_STEP, DW'(lir_pkg::PHASE_STEP_RST));
		send_word(SW'(7), 1'b0);
		set_reg(ADDR_SPARE, '1);
		send_word(-SW'(7), 1'b1);
	endtask

	task automatic test_random(input int count, input int unsigned lo, input int unsigned hi,
			input bit quiet);
		int left;
		int run;
		set_reg(ADDR_STEP, DW'($urandom_range(hi, lo)));
		calm = quiet;
		left = count;
		while (left > 0) begin
			run = $urandom_range(1, 10);
			for (int i = 0; i < run && left > 0; i++) begin
				send_word(pick_sample(), (i == run - 1) || ($urandom_range(0, 15) == 0));
				left--;
			end
		end
		calm = 1'b0;
	endtask

	initial begin : run_tests
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_copy();
		test_lone_sample();
		test_upsample();
		test_downsample();
		test_zero_step();
		test_top_step();
		test_spare_reg();
		test_random(32, 40000, 100000, 1'b0);
		test_random(20, 16384, 131072, 1'b1);
		test_random(12, 2048, 16384, 1'b0);
		test_random(20, 131072, 2097152, 1'b0);
		test_random(12, 0, 4194303, 1'b0);
		drain();
		$display("summary: %0d words in, %0d words out, %0d register writes", n_in, n_out, n_cfg);
		$display("summary: steps from zero to full scale, copy, up- and downsampling runs");
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
